// File: hdl/tmt_pkg.sv
// ---------------------------------------------------------------------------
// tmt_pkg
// Shared constants and controller/datapath interface types for the table
// minimum tracker.
// ---------------------------------------------------------------------------
package tmt_pkg;

  localparam int IDX_W       = 10;
  localparam int VAL_IN_W    = 30;
  localparam int VAL_W       = 31;
  localparam int SIZE_W      = 11;
  localparam int TABLE_DEPTH = 1 << IDX_W;

  localparam logic [VAL_W-1:0]  VALUE_MAX  = {VAL_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;   // write VALUE_MAX at the sweep address
    logic cap;        // capture the input item
    logic eval;       // apply the captured write
    logic addr_clr;   // rewind the sweep address
    logic scan_rd;    // issue a rescan read
    logic emit;       // load the result registers
  } tmt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_rescan;
    logic clear_last;
    logic scan_last;
  } tmt_sts_t;

endpackage

// File: hdl/tmt_ram.sv
// ---------------------------------------------------------------------------
// tmt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module tmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/tmt_dp.sv
// ---------------------------------------------------------------------------
// tmt_dp
// Datapath: size register, input capture, table RAM, tracked minimum,
// sweep address counter and result registers.
// ---------------------------------------------------------------------------
module tmt_dp
  import tmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  tmt_cmd_t            cmd,
  output tmt_sts_t            sts,
  input  logic [IDX_W-1:0]    in_write_index,
  input  logic [VAL_IN_W-1:0] in_write_value,
  input  logic                cfg_valid,
  input  logic [SIZE_W-1:0]   cfg_table_size,
  output logic                out_valid,
  output logic [VAL_W-1:0]    out_min_value,
  output logic [IDX_W-1:0]    out_min_index,
  output logic                out_accepted
);

  logic [SIZE_W-1:0]   table_size_r;
  logic [SIZE_W-1:0]   size_use;
  logic [IDX_W-1:0]    idx_r;
  logic [VAL_IN_W-1:0] val_r;
  logic [VAL_W-1:0]    val_ext;
  logic [VAL_W-1:0]    cur_min_r, cur_min_nxt;
  logic [IDX_W-1:0]    min_pos_r, min_pos_nxt;
  logic                have_min_r, have_min_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic [IDX_W-1:0]    last_addr;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_addr_r;
  logic [VAL_W-1:0]    rd_data;
  logic                in_range;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic                out_valid_r;
  logic [VAL_W-1:0]    out_min_value_r;
  logic [IDX_W-1:0]    out_min_index_r;
  logic                out_accepted_r;

  assign size_use  = (table_size_r > SIZE_RESET) ? SIZE_RESET : table_size_r;
  assign in_range  = {1'b0, idx_r} < size_use;
  assign val_ext   = {1'b0, val_r};
  assign last_addr = IDX_W'(size_use - SIZE_W'(1));

  assign sts.need_rescan = in_range && have_min_r && (idx_r == min_pos_r) &&
                           (val_ext > cur_min_r);
  assign sts.clear_last  = (addr_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.scan_last   = (addr_r == last_addr);

  // single write port shared by the post-reset clear and item writes
  assign ram_we    = cmd.clear_wr || (cmd.eval && in_range);
  assign ram_waddr = cmd.clear_wr ? addr_r : idx_r;
  assign ram_wdata = cmd.clear_wr ? VALUE_MAX : val_ext;

  tmt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.scan_rd),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    cur_min_nxt  = cur_min_r;
    min_pos_nxt  = min_pos_r;
    have_min_nxt = have_min_r;
    if (cmd.eval && in_range) begin
      if (!have_min_r) begin
        have_min_nxt = 1'b1;
        cur_min_nxt  = val_ext;
        min_pos_nxt  = idx_r;
      end else if (idx_r == min_pos_r) begin
        // a raise also seeds the rescan with the written entry
        cur_min_nxt = val_ext;
      end else if (val_ext < cur_min_r) begin
        cur_min_nxt = val_ext;
        min_pos_nxt = idx_r;
      end
    end
    if (rd_vld_r && (rd_data < cur_min_r)) begin
      cur_min_nxt = rd_data;
      min_pos_nxt = rd_addr_r;
    end
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.addr_clr) begin
      addr_nxt = '0;
    end else if (cmd.clear_wr || cmd.scan_rd) begin
      addr_nxt = addr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
      cur_min_r    <= VALUE_MAX;
      min_pos_r    <= '0;
      have_min_r   <= 1'b0;
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        table_size_r <= cfg_table_size;
      end
      cur_min_r   <= cur_min_nxt;
      min_pos_r   <= min_pos_nxt;
      have_min_r  <= have_min_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= cmd.scan_rd;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      idx_r <= in_write_index;
      val_r <= in_write_value;
    end
    if (cmd.scan_rd) begin
      rd_addr_r <= addr_r;
    end
    if (cmd.emit) begin
      out_min_value_r <= cur_min_nxt;
      out_min_index_r <= min_pos_nxt;
      out_accepted_r  <= in_range;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_value_r;
  assign out_min_index = out_min_index_r;
  assign out_accepted  = out_accepted_r;

endmodule

// File: hdl/tmt_ctrl.sv
// ---------------------------------------------------------------------------
// tmt_ctrl
// Controller: post-reset table clear, item evaluation and rescan sequencing.
// ---------------------------------------------------------------------------
module tmt_ctrl
  import tmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tmt_sts_t sts,
  output tmt_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_TAIL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval     = 1'b1;
        cmd.addr_clr = 1'b1;
        if (sts.need_rescan) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // last read data is compared this cycle
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: hdl/table_min_tracker_core.sv
// ---------------------------------------------------------------------------
// table_min_tracker_core
// Running minimum over a 1024-entry value table under point writes, with a
// lazy full rescan when the tracked minimum is raised.
// ---------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  input   | start / busy             | in_write_index, in_write_value
//  result  | out_valid (1-cycle)      | out_min_value, out_min_index,
//          |                          | out_accepted
//  config  | cfg_valid / cfg_ready    | cfg_table_size
//
//  Without a rescan, an item goes from accept through ST_EVAL to the result
//  strobe; busy is low again when the result shows, so a new item can be
//  taken while the result shows. A write that raises the tracked minimum
//  rescans the size-in-use table entries over the one RAM read port in ST_SCAN.
//  After reset the table is cleared to all ones, one entry a cycle: busy
//  stays high until the clear is done. Config writes are taken at any time.
//  The result receiver cannot stall; each result is held one cycle only.
// ---------------------------------------------------------------------------
module table_min_tracker_core
  import tmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [IDX_W-1:0]    in_write_index,
  input  logic [VAL_IN_W-1:0] in_write_value,
  output logic                out_valid,
  output logic [VAL_W-1:0]    out_min_value,
  output logic [IDX_W-1:0]    out_min_index,
  output logic                out_accepted,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   cfg_table_size
);

  tmt_cmd_t cmd;
  tmt_sts_t sts;

  assign cfg_ready = 1'b1;

  tmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tmt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_write_index (in_write_index),
    .in_write_value (in_write_value),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_table_size (cfg_table_size),
    .out_valid      (out_valid),
    .out_min_value  (out_min_value),
    .out_min_index  (out_min_index),
    .out_accepted   (out_accepted)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accept");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on consecutive cycles");
`endif

endmodule
